// ===== rtl/crph_pkg.sv =====
// Shared types, constants and helpers for the CSV record parse and hash block.
package crph_pkg;

  // Default bucket count of the hash tables.
  localparam int NUM_BUCKETS_DEF = 400;

  // Result kinds carried on the result channel's tuser.
  localparam logic [1:0] STATUS_CITY   = 2'd0;
  localparam logic [1:0] STATUS_ACCEPT = 2'd1;
  localparam logic [1:0] STATUS_ERROR  = 2'd2;

  // Characters that steer the parser.
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_PAREN = 8'h28;

  // Saturation limits of the accumulators.
  localparam logic [19:0] RANK_MAX = 20'hFFFFF;
  localparam logic [31:0] POP_MAX  = 32'hFFFFFFFF;
  localparam logic [9:0]  LEN_MAX  = 10'd1023;

  // Result word as it leaves the parser.
  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  city_byte;
    logic [19:0] rank;
    logic [31:0] population;
    logic [9:0]  city_length;
    logic [8:0]  index_by_length;
    logic [8:0]  index_by_sum;
    logic [8:0]  index_by_product;
  } result_t;

  // Bits needed to hold a remainder modulo the table size.
  function automatic int idx_width(input int ts);
    return (ts > 1) ? $clog2(ts) : 1;
  endfunction

endpackage

// ===== rtl/crph_prod_mod.sv =====
// Pipelined modulo of the product of the first two city bytes by the table size.
module crph_prod_mod #(
  parameter int NUM_BUCKETS = crph_pkg::NUM_BUCKETS_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         load,
  input  logic [7:0]                                   op_a,
  input  logic [7:0]                                   op_b,
  output logic [crph_pkg::idx_width(NUM_BUCKETS)-1:0] idx_o
);

  localparam int IW = crph_pkg::idx_width(NUM_BUCKETS);
  // Reciprocal scaled by 2^16; the quotient estimate is at most one low.
  localparam logic [16:0] RECIP = 17'(65536 / NUM_BUCKETS);
  localparam logic [15:0] TS16  = 16'(NUM_BUCKETS);

  logic [15:0] prod_r;
  logic [15:0] quot_r;
  logic [15:0] mult_r;
  logic [32:0] quot_full;
  logic [31:0] mult_full;
  logic [15:0] rem;
  logic [15:0] rem_fix;

  assign quot_full = 33'(prod_r) * 33'(RECIP);
  assign mult_full = 32'(quot_r) * 32'(TS16);

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= 16'(op_a) * 16'(op_b);
    end
    quot_r <= quot_full[31:16];
    mult_r <= mult_full[15:0];
  end

  assign rem     = prod_r - mult_r;
  assign rem_fix = (rem >= TS16) ? (rem - TS16) : rem;
  assign idx_o   = IW'(rem_fix);

`ifndef SYNTHESIS
  // Once the product, quotient and multiple registers have followed a load, the remainder lies below the table size.
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> ##3 (rem_fix < TS16))
    else $error("product remainder out of range");
`endif

endmodule

// ===== rtl/crph_parse.sv =====
// Byte-serial record parser with rank, population, length and hash accumulators.
module crph_parse #(
  parameter int NUM_BUCKETS = crph_pkg::NUM_BUCKETS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [7:0]        in_char,
  input  logic              in_last,
  output logic              res_valid,
  output crph_pkg::result_t res
);

  localparam int IW = crph_pkg::idx_width(NUM_BUCKETS);
  localparam logic [IW:0]   TS_W   = (IW+1)'(NUM_BUCKETS);
  localparam logic [IW-1:0] TS_M1  = IW'(NUM_BUCKETS - 1);

  localparam logic [3:0] S_START      = 4'd0;
  localparam logic [3:0] S_RANK       = 4'd1;
  localparam logic [3:0] S_OPEN_CITY  = 4'd2;
  localparam logic [3:0] S_CITY       = 4'd3;
  localparam logic [3:0] S_AFTER_CITY = 4'd4;
  localparam logic [3:0] S_POP_OPEN   = 4'd5;
  localparam logic [3:0] S_POP        = 4'd6;
  localparam logic [3:0] S_SKIP       = 4'd7;

  logic [3:0]    state_r,   state_nxt;
  logic [19:0]   rank_r,    rank_nxt;
  logic [31:0]   pop_r,     pop_nxt;
  logic [9:0]    len_r,     len_nxt;
  logic [IW-1:0] len_mod_r, len_mod_nxt;
  logic [IW-1:0] sum_r,     sum_nxt;
  logic [7:0]    first_r,   first_nxt;

  logic          acc;
  logic          is_digit;
  logic [3:0]    digit;
  logic [23:0]   rank_mul;
  logic [35:0]   pop_mul;
  logic [IW:0]   sum_add;
  logic          prod_load;
  logic [IW-1:0] prod_idx;
  logic          emit;
  logic [1:0]    status;

  // Byte value modulo the table size, a constant lookup.
  logic [IW-1:0] byte_mod [256];
  for (genvar g = 0; g < 256; g++) begin : g_byte_mod
    assign byte_mod[g] = IW'(g % NUM_BUCKETS);
  end

  assign acc      = in_valid && in_ready;
  assign is_digit = (in_char >= crph_pkg::CH_ZERO) && (in_char <= crph_pkg::CH_NINE);
  assign digit    = 4'(in_char - crph_pkg::CH_ZERO);
  assign rank_mul = (24'(rank_r) << 3) + (24'(rank_r) << 1) + 24'(digit);
  assign pop_mul  = (36'(pop_r) << 3) + (36'(pop_r) << 1) + 36'(digit);
  assign sum_add  = (IW+1)'(sum_r) + (IW+1)'(byte_mod[in_char]);

  always_comb begin
    state_nxt   = state_r;
    rank_nxt    = rank_r;
    pop_nxt     = pop_r;
    len_nxt     = len_r;
    len_mod_nxt = len_mod_r;
    sum_nxt     = sum_r;
    first_nxt   = first_r;
    prod_load   = 1'b0;
    emit        = 1'b0;
    status      = crph_pkg::STATUS_CITY;
    if (acc) begin
      unique case (state_r)
        S_START: begin
          if (is_digit) begin
            rank_nxt  = 20'(digit);
            state_nxt = S_RANK;
          end else begin
            emit   = 1'b1;
            status = crph_pkg::STATUS_ERROR;
          end
        end
        S_RANK: begin
          if (is_digit) begin
            rank_nxt = (rank_mul > 24'(crph_pkg::RANK_MAX)) ? crph_pkg::RANK_MAX
                                                             : rank_mul[19:0];
          end else if (in_char == crph_pkg::CH_COMMA) begin
            state_nxt = S_OPEN_CITY;
          end else begin
            emit   = 1'b1;
            status = crph_pkg::STATUS_ERROR;
          end
        end
        S_OPEN_CITY: begin
          if (in_char == crph_pkg::CH_QUOTE) begin
            state_nxt = S_CITY;
          end else begin
            emit   = 1'b1;
            status = crph_pkg::STATUS_ERROR;
          end
        end
        S_CITY: begin
          if (in_char == crph_pkg::CH_QUOTE) begin
            state_nxt = S_AFTER_CITY;
          end else begin
            if (len_r == 10'd0) begin
              first_nxt = in_char;
            end
            prod_load = (len_r == 10'd1);
            if (len_r < crph_pkg::LEN_MAX) begin
              len_nxt     = len_r + 10'd1;
              len_mod_nxt = (len_mod_r == TS_M1) ? '0 : len_mod_r + IW'(1);
            end
            sum_nxt = (sum_add >= TS_W) ? IW'(sum_add - TS_W) : IW'(sum_add);
            emit    = 1'b1;
            status  = crph_pkg::STATUS_CITY;
          end
        end
        S_AFTER_CITY: begin
          if (in_char == crph_pkg::CH_COMMA) begin
            state_nxt = S_POP_OPEN;
          end else begin
            emit   = 1'b1;
            status = crph_pkg::STATUS_ERROR;
          end
        end
        S_POP_OPEN: begin
          if (in_char == crph_pkg::CH_QUOTE) begin
            state_nxt = S_POP;
          end else if (in_char == crph_pkg::CH_PAREN) begin
            pop_nxt = '0;
            emit    = 1'b1;
            status  = crph_pkg::STATUS_ACCEPT;
          end else begin
            emit   = 1'b1;
            status = crph_pkg::STATUS_ERROR;
          end
        end
        S_POP: begin
          if (is_digit) begin
            pop_nxt = (pop_mul > 36'(crph_pkg::POP_MAX)) ? crph_pkg::POP_MAX
                                                          : pop_mul[31:0];
          end else if (in_char == crph_pkg::CH_QUOTE) begin
            emit   = 1'b1;
            status = crph_pkg::STATUS_ACCEPT;
          end else if (in_char != crph_pkg::CH_COMMA) begin
            emit   = 1'b1;
            status = crph_pkg::STATUS_ERROR;
          end
        end
        S_SKIP: begin
        end
        default: begin
          emit   = 1'b1;
          status = crph_pkg::STATUS_ERROR;
        end
      endcase

      // A line that ends before the record is finished is malformed.
      if (in_last && (state_r != S_SKIP) && (!emit || status == crph_pkg::STATUS_CITY)) begin
        emit   = 1'b1;
        status = crph_pkg::STATUS_ERROR;
      end

      if (in_last) begin
        state_nxt   = S_START;
        rank_nxt    = '0;
        pop_nxt     = '0;
        len_nxt     = '0;
        len_mod_nxt = '0;
        sum_nxt     = '0;
        first_nxt   = '0;
      end else if (emit && status != crph_pkg::STATUS_CITY) begin
        state_nxt = S_SKIP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_START;
      rank_r    <= '0;
      pop_r     <= '0;
      len_r     <= '0;
      len_mod_r <= '0;
      sum_r     <= '0;
      first_r   <= '0;
    end else begin
      state_r   <= state_nxt;
      rank_r    <= rank_nxt;
      pop_r     <= pop_nxt;
      len_r     <= len_nxt;
      len_mod_r <= len_mod_nxt;
      sum_r     <= sum_nxt;
      first_r   <= first_nxt;
    end
  end

  crph_prod_mod #(
    .NUM_BUCKETS (NUM_BUCKETS)
  ) u_prod_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (prod_load),
    .op_a  (first_r),
    .op_b  (in_char),
    .idx_o (prod_idx)
  );

  // Result word; fields that do not belong to the result kind read as zero.
  always_comb begin
    res        = '0;
    res.status = status;
    if (status == crph_pkg::STATUS_CITY) begin
      res.city_byte = in_char;
    end else if (status == crph_pkg::STATUS_ACCEPT) begin
      res.rank             = rank_r;
      res.population       = pop_r;
      res.city_length      = len_r;
      res.index_by_length  = 9'(16'(len_mod_r));
      res.index_by_sum     = 9'(16'(sum_r));
      res.index_by_product = (len_r < 10'd2) ? 9'd0 : 9'(16'(prod_idx));
    end
  end

  assign res_valid = emit;

`ifndef SYNTHESIS
  // The byte that closes a line always sends the parser back to line start.
  a_line_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_last) |=> (state_r == S_START))
    else $error("parser did not return to line start");

  // Bytes after an accept or an error give no result, the line's last byte included.
  a_skip_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && state_r == S_SKIP) |-> !res_valid)
    else $error("result while skipping rest of line");
`endif

endmodule

// ===== rtl/crph_out_buf.sv =====
// Output register with one skid entry for the result channel.
module crph_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  crph_pkg::result_t push_data,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output crph_pkg::result_t out_data
);

  logic              out_valid_r;
  logic              skid_valid_r;
  crph_pkg::result_t out_data_r;
  crph_pkg::result_t skid_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      out_data_r <= skid_valid_r ? skid_data_r : push_data;
    end else if (push) begin
      skid_data_r <= push_data;
    end
  end

  assign in_ready  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // The skid entry only ever holds a word younger than the one on the output.
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without output word");

  // A new result never arrives while the skid entry is occupied.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !skid_valid_r)
    else $error("result pushed into full buffer");
`endif

endmodule

// ===== rtl/csv_record_parse_and_hash.sv =====
// Top level of the CSV record parser with city hash bucket indices.
//
//  Channel   Direction  Fields (tdata / tuser / tlast)
//  in_*      input      tdata[7:0] char_in; tlast line_end
//  out_*     output     tuser[1:0] status; tdata city_byte, rank, population,
//                       city_length, index_by_length, index_by_sum, index_by_product
//
// Each input word is parsed in the cycle it is accepted and its result, if any,
// is registered, so the block takes one byte per clock cycle while in_tready is
// high. The product bucket index comes from a three-stage reciprocal-multiply
// pipeline that settles in the very cycle of the earliest possible accept, three
// bytes after the second city byte.
// Reset is synchronous and active low; it returns the parser to line start and
// empties the output buffer. A stalled output is absorbed by a one-word skid
// entry; in_tready drops only once that entry is also full.
module csv_record_parse_and_hash #(
  parameter int NUM_BUCKETS = crph_pkg::NUM_BUCKETS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] char_in
  input  logic         in_tlast,   // line_end
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // [7:0] city_byte, [27:8] rank, [59:28] population,
                                   // [69:60] city_length, [78:70] index_by_length,
                                   // [87:79] index_by_sum, [96:88] index_by_product,
                                   // [103:97] zero
  output logic [1:0]   out_tuser   // [1:0] status
);

  logic              res_valid;
  crph_pkg::result_t res;
  crph_pkg::result_t out_word;

  // Parser and accumulators; all work on a byte but the product modulo happens in its accept cycle.
  crph_parse #(
    .NUM_BUCKETS (NUM_BUCKETS)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_char   (in_tdata),
    .in_last   (in_tlast),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output register plus skid entry so input keeps flowing under a brief stall.
  crph_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_word)
  );

  assign out_tuser = out_word.status;
  assign out_tdata = {7'd0,
                      out_word.index_by_product,
                      out_word.index_by_sum,
                      out_word.index_by_length,
                      out_word.city_length,
                      out_word.population,
                      out_word.rank,
                      out_word.city_byte};

endmodule

// ===== tb/sv/tb_csv_record_parse_and_hash.sv =====
// Self-checking testbench for the CSV record parser with city hash bucket indices.
module tb_csv_record_parse_and_hash;
  import crph_pkg::*;

  localparam int TS           = NUM_BUCKETS_DEF;
  localparam int HALF_PERIOD  = 10;
  localparam int RANDOM_WORDS = 950;
  localparam int HOLD_AT      = 40;
  localparam int HOLD_CYCLES  = 150;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int REPORT_LIMIT = 10;

  // Idling schemes, stepped through as the run proceeds.
  localparam int MODE_NONE     = 0;
  localparam int MODE_SENDER   = 1;
  localparam int MODE_RECEIVER = 2;
  localparam int MODE_BOTH     = 3;

  // Every input is driven to a known value from time zero.
  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic [7:0]   in_tdata   = '0;
  logic         in_tlast   = 1'b0;
  logic         out_tready = 1'b0;
  logic         in_tready;
  logic         out_tvalid;
  logic [103:0] out_tdata;
  logic [1:0]   out_tuser;

  csv_record_parse_and_hash #(.NUM_BUCKETS(TS)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Line parser mirror plus the queue of result words it predicts. Each
  // accepted input word is fed to note_word; each accepted output word is
  // matched against the oldest prediction by check_result.
  class parse_scoreboard;
    typedef enum logic [3:0] {
      LINE_START, IN_RANK, OPEN_CITY, IN_CITY, AFTER_CITY, POP_OPEN, IN_POP, SKIP_REST
    } line_state_e;
    typedef enum {NO_WORD, CITY_WORD, ACCEPT_WORD, ERROR_WORD} outcome_e;

    result_t     expected_q[$];
    line_state_e state;
    logic [19:0] rank;
    logic [31:0] population;
    logic [9:0]  city_len;
    int unsigned byte_sum;
    logic [7:0]  first_byte;
    int unsigned product;
    int          failures;
    int          city_words;
    int          accepts;
    int          errors;

    function new();
      failures   = 0;
      city_words = 0;
      accepts    = 0;
      errors     = 0;
      clear_line();
    endfunction

    function void clear_line();
      state      = LINE_START;
      rank       = '0;
      population = '0;
      city_len   = '0;
      byte_sum   = 0;
      first_byte = '0;
      product    = 0;
    endfunction

    function bit is_digit(input logic [7:0] b);
      return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_word(input logic [7:0] b, input bit line_end);
      outcome_e    outcome;
      result_t     r;
      logic [63:0] wide;
      outcome = NO_WORD;
      r       = '0;
      case (state)
        LINE_START:
          if (is_digit(b)) begin
            rank  = 20'(b - CH_ZERO);
            state = IN_RANK;
          end else begin
            outcome = ERROR_WORD;
          end
        IN_RANK:
          if (is_digit(b)) begin
            wide = 64'(rank) * 64'd10 + 64'(b - CH_ZERO);
            rank = (wide > 64'(RANK_MAX)) ? RANK_MAX : wide[19:0];
          end else if (b == CH_COMMA) begin
            state = OPEN_CITY;
          end else begin
            outcome = ERROR_WORD;
          end
        OPEN_CITY:
          if (b == CH_QUOTE) state = IN_CITY;
          else outcome = ERROR_WORD;
        IN_CITY:
          if (b == CH_QUOTE) begin
            state = AFTER_CITY;
          end else begin
            if (city_len == 0) first_byte = b;
            else if (city_len == 1) product = (32'(first_byte) * 32'(b)) % TS;
            if (city_len < LEN_MAX) city_len++;
            byte_sum = (byte_sum + b) % TS;
            outcome  = CITY_WORD;
          end
        AFTER_CITY:
          if (b == CH_COMMA) state = POP_OPEN;
          else outcome = ERROR_WORD;
        POP_OPEN:
          if (b == CH_QUOTE) begin
            state = IN_POP;
          end else if (b == CH_PAREN) begin
            population = '0;
            outcome    = ACCEPT_WORD;
          end else begin
            outcome = ERROR_WORD;
          end
        IN_POP:
          if (is_digit(b)) begin
            wide       = 64'(population) * 64'd10 + 64'(b - CH_ZERO);
            population = (wide > 64'(POP_MAX)) ? POP_MAX : wide[31:0];
          end else if (b == CH_QUOTE) begin
            outcome = ACCEPT_WORD;
          end else if (b != CH_COMMA) begin
            outcome = ERROR_WORD;
          end
        SKIP_REST: ;
        default: outcome = ERROR_WORD;
      endcase

      // A line that stops before its record is complete is malformed, and
      // that error takes the place of a city byte on the same word.
      if (line_end && state != SKIP_REST && outcome != ACCEPT_WORD && outcome != ERROR_WORD)
        outcome = ERROR_WORD;

      case (outcome)
        CITY_WORD: begin
          r.status    = STATUS_CITY;
          r.city_byte = b;
        end
        ACCEPT_WORD: begin
          r.status           = STATUS_ACCEPT;
          r.rank             = rank;
          r.population       = population;
          r.city_length      = city_len;
          r.index_by_length  = 9'(city_len % TS);
          r.index_by_sum     = 9'(byte_sum);
          r.index_by_product = (city_len < 2) ? 9'd0 : 9'(product);
        end
        ERROR_WORD: r.status = STATUS_ERROR;
        default: ;
      endcase
      if (outcome != NO_WORD) expected_q.push_back(r);

      if (line_end) clear_line();
      else if (outcome == ACCEPT_WORD || outcome == ERROR_WORD) state = SKIP_REST;
    endfunction

    function void show(input string tag, input result_t r);
      $display("%s status=%0d byte=%02h rank=%0d pop=%0d len=%0d idx=%0d/%0d/%0d", tag,
               r.status, r.city_byte, r.rank, r.population, r.city_length,
               r.index_by_length, r.index_by_sum, r.index_by_product);
    endfunction

    function void check_result(input logic [1:0] tuser, input logic [103:0] tdata);
      result_t want;
      result_t got;
      string   wrong;
      got.status           = tuser;
      got.city_byte        = tdata[7:0];
      got.rank             = tdata[27:8];
      got.population       = tdata[59:28];
      got.city_length      = tdata[69:60];
      got.index_by_length  = tdata[78:70];
      got.index_by_sum     = tdata[87:79];
      got.index_by_product = tdata[96:88];
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT) show("unexpected result word:", got);
        return;
      end
      want = expected_q.pop_front();
      case (want.status)
        STATUS_CITY:   city_words++;
        STATUS_ACCEPT: accepts++;
        default:       errors++;
      endcase
      wrong = "";
      if (got.status !== want.status) wrong = {wrong, " status"};
      if (got.city_byte !== want.city_byte) wrong = {wrong, " city_byte"};
      if (got.rank !== want.rank) wrong = {wrong, " rank"};
      if (got.population !== want.population) wrong = {wrong, " population"};
      if (got.city_length !== want.city_length) wrong = {wrong, " city_length"};
      if (got.index_by_length !== want.index_by_length) wrong = {wrong, " index_by_length"};
      if (got.index_by_sum !== want.index_by_sum) wrong = {wrong, " index_by_sum"};
      if (got.index_by_product !== want.index_by_product) wrong = {wrong, " index_by_product"};
      if (tdata[103:97] !== 7'd0) wrong = {wrong, " padding"};
      if (wrong != "") begin
        failures++;
        if (failures <= REPORT_LIMIT) begin
          $display("result word mismatch in%s", wrong);
          show("  expected", want);
          show("  actual  ", got);
        end
      end
    endfunction
  endclass

  parse_scoreboard sb;

  // Stimulus is built up front as a list of bytes with a line-end flag each.
  logic [7:0] line_buf[$];
  logic [7:0] stim_byte[$];
  bit         stim_end[$];

  int words_sent = 0;
  int idle_mode  = MODE_NONE;
  int cycles     = 0;
  bit hold_done  = 1'b0;

  // The clock idles low and rises first after half a period.
  always begin
    #(HALF_PERIOD) clk = 1'b1;
    #(HALF_PERIOD) clk = 1'b0;
  end

  function automatic bit chance(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic void add_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  // Decimal digits, optionally sprinkled with the commas a population may carry.
  function automatic void add_digits(input int n, input bit with_commas);
    int i;
    for (i = 0; i < n; i++) begin
      line_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      if (with_commas && chance(25)) line_buf.push_back(CH_COMMA);
    end
  endfunction

  // A city byte is anything but the closing quote; half of them are letters so
  // that the lines look like real data, the rest cover the full byte range.
  function automatic logic [7:0] city_char();
    logic [7:0] b;
    do begin
      b = chance(50) ? 8'($urandom_range(8'h61, 8'h7A)) : 8'($urandom);
    end while (b == CH_QUOTE);
    return b;
  endfunction

  function automatic void build_record(input int rank_digits, input int city_bytes,
                                       input int pop_digits, input bit paren);
    add_digits(rank_digits, 1'b0);
    line_buf.push_back(CH_COMMA);
    line_buf.push_back(CH_QUOTE);
    repeat (city_bytes) line_buf.push_back(city_char());
    line_buf.push_back(CH_QUOTE);
    line_buf.push_back(CH_COMMA);
    if (paren) begin
      line_buf.push_back(CH_PAREN);
    end else begin
      line_buf.push_back(CH_QUOTE);
      add_digits(pop_digits, 1'b1);
      line_buf.push_back(CH_QUOTE);
    end
  endfunction

  // Moves the line under construction to the stimulus, flagging its last byte.
  function automatic void flush_line();
    int i;
    for (i = 0; i < line_buf.size(); i++) begin
      stim_byte.push_back(line_buf[i]);
      stim_end.push_back(i == line_buf.size() - 1);
    end
    line_buf.delete();
  endfunction

  // One random line: mostly well-formed records, some broken by truncation or
  // a corrupted byte, and some pure noise. Returns the number of bytes in the
  // line, ignored trailing bytes after an accept included.
  function automatic int random_line();
    int pick;
    int counted;
    int cut;
    pick = $urandom_range(0, 99);
    if (pick < 85) begin
      build_record(chance(10) ? $urandom_range(7, 9) : $urandom_range(1, 4),
                   $urandom_range(0, 12),
                   chance(10) ? $urandom_range(10, 13) : $urandom_range(0, 8),
                   chance(25));
      if (pick >= 70) begin
        if (chance(50)) begin
          cut = $urandom_range(1, line_buf.size() - 1);
          while (line_buf.size() > cut) void'(line_buf.pop_back());
        end else begin
          line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom);
        end
      end
    end else begin
      repeat ($urandom_range(1, 6)) line_buf.push_back(8'($urandom));
    end
    if (pick < 70 && chance(25))
      repeat ($urandom_range(1, 4)) line_buf.push_back(8'($urandom));
    counted = line_buf.size();
    flush_line();
    return counted;
  endfunction

  // The run walks through five stretches: no idling, sender gaps, receiver
  // stalls, light idling on both sides, and a final stretch with no idling.
  function automatic int mode_for(input int idx, input int total);
    case ((idx * 5) / total)
      1:       return MODE_SENDER;
      2:       return MODE_RECEIVER;
      3:       return MODE_BOTH;
      default: return MODE_NONE;
    endcase
  endfunction

  // Offers each word at a falling edge and holds it until a rising edge sees
  // in_tready high. Idle cycles carry random data that must be ignored.
  task automatic drive_words();
    int i;
    for (i = 0; i < stim_byte.size(); i++) begin
      idle_mode = mode_for(i, stim_byte.size());
      while (chance(idle_mode == MODE_SENDER ? 53 : (idle_mode == MODE_BOTH ? 7 : 0))) begin
        in_tvalid <= 1'b0;
        in_tdata  <= 8'($urandom);
        in_tlast  <= 1'($urandom);
        @(negedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= stim_byte[i];
      in_tlast  <= stim_end[i];
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      sb.note_word(stim_byte[i], stim_end[i]);
      words_sent = i + 1;
      @(negedge clk);
    end
    in_tvalid <= 1'b0;
  endtask

  // Receiver side. Early in the run it refuses output words for a long
  // stretch while the sender keeps going, so the output buffer fills and the
  // block has to push back on its input.
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!hold_done && words_sent >= HOLD_AT) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      out_tready <= !chance(idle_mode == MODE_RECEIVER ? 53 :
                            (idle_mode == MODE_BOTH ? 7 : 0));
    end
  end

  // Output words are taken at the rising edge where valid and ready meet.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding", cycles, sb.pending());
      $display("tb_csv_record_parse_and_hash: FAIL");
      $finish;
    end
  end

  initial begin
    int counted;
    sb = new();

    // Directed lines. Rank zero with an empty city and a parenthesis
    // population, accepted on the line's last byte.
    add_text("0,\"\",(");
    flush_line();
    // Saturating rank, the extreme byte values inside the city, an empty
    // quoted population, then bytes after the accept that must be ignored.
    add_text("9999999,\"");
    line_buf.push_back(8'hFF);
    line_buf.push_back(8'h00);
    add_text("\",\"\"x(");
    flush_line();
    // A line that is bad from its first byte.
    add_text("A");
    flush_line();
    // A line that ends inside the city: the error replaces the city byte.
    add_text("5,\"Q");
    flush_line();

    // Random lines until the stimulus holds about the planned number of bytes.
    counted = 0;
    while (counted < RANDOM_WORDS) begin
      counted += random_line();
    end

    // Reset is held low from time zero and released at a falling edge.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    drive_words();

    // Wait for every predicted word, then let the clock run on to catch strays.
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bytes in records, broken lines and noise over %0d cycles.",
             stim_byte.size(), cycles);
    $display("Checked %0d city bytes, %0d accepted records and %0d malformed lines.",
             sb.city_words, sb.accepts, sb.errors);
    if (sb.failures == 0) begin
      $display("tb_csv_record_parse_and_hash: PASS");
    end else begin
      $display("%0d result words failed their checks", sb.failures);
      $display("tb_csv_record_parse_and_hash: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/crph_pkg.sv
rtl/crph_prod_mod.sv
rtl/crph_parse.sv
rtl/crph_out_buf.sv
rtl/csv_record_parse_and_hash.sv
tb/sv/tb_csv_record_parse_and_hash.sv
